// File: rtl/lbm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the D2Q9 BGK collision block.
package lbm_pkg;
	localparam int NDIR = 9;
	localparam int DW = 32;
	localparam int RELAX_W = 29;
	localparam int ISS_W = 31;
	localparam int FRAC_BITS_DEF = 27;
	localparam logic [RELAX_W-1:0] RELAX_RST = 29'd134217728;
	localparam logic [ISS_W-1:0] ISS_RST = 31'd402653184;

	localparam logic CFG_RELAX_RATE = 1'b0;
	localparam logic CFG_INV_SOUND_SPEED_SQ = 1'b1;
	localparam int CFG_IDX_W = 1;

	typedef logic signed [DW-1:0] word_t;
	typedef word_t [NDIR-1:0] pop_t;

	typedef struct packed {
		pop_t f;
		logic apply_collision;
	} node_in_t;

	typedef struct packed {
		pop_t g;
		word_t density;
		word_t velocity_x;
		word_t velocity_y;
	} node_out_t;

	function automatic word_t sat32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [2:0] dir_cx(input int k);
		case (k)
			2, 3, 4: return 3'sd1;
			6, 7, 8: return -3'sd1;
			default: return 3'sd0;
		endcase
	endfunction

	function automatic logic signed [2:0] dir_cy(input int k);
		case (k)
			1, 2, 8: return 3'sd1;
			4, 5, 6: return -3'sd1;
			default: return 3'sd0;
		endcase
	endfunction

	function automatic logic [4:0] dir_wnum(input int k);
		case (k)
			0: return 5'd16;
			1, 3, 5, 7: return 5'd4;
			default: return 5'd1;
		endcase
	endfunction
endpackage

// File: rtl/lbm_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload.
interface lbm_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/lbm_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel interface.
interface lbm_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] index;
	logic [31:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/d2q9_bgk_node_collision.sv
`timescale 1ns / 1ps
// D2Q9 BGK collision for one lattice node per cycle while the output is not stalled.
// Usage:
//   node_in (sink) takes the nine populations and apply_collision of a node.
//   node_out (source) gives the nine relaxed populations, density, velocity.
//   cfg (sink) writes relax_rate (index 0) or inv_sound_speed_sq (index 1);
//   other indexes are ignored. Write only while the pipeline is empty.
// Throughput: one node per cycle while the output is not stalled.
// Pipeline: FRAC_BITS+45 register stages (72 at Q4.27): one sum stage, the
//   velocity divider (an entry stage plus one quotient bit per stage), six
//   collision stages, and the output register.
// Reset clears all valid bits and loads the register reset values.
// Stall: the whole pipeline holds while the output request is not taken;
//   the input is ready whenever the output register is empty or draining.
module d2q9_bgk_node_collision #(
	parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	lbm_stream_if.sink node_in,
	lbm_stream_if.source node_out,
	lbm_cfg_if.sink cfg
);
	localparam int N = lbm_pkg::NDIR;
	typedef struct packed {
		lbm_pkg::pop_t f;
		logic apply;
		lbm_pkg::word_t rho;
		logic signed [35:0] my;
	} tag_t;

	logic [lbm_pkg::RELAX_W-1:0] relax_q;
	logic [lbm_pkg::ISS_W-1:0] iss_q;
	logic en;
	logic v_s1;
	lbm_pkg::node_in_t in_s1;
	lbm_pkg::word_t rho_s1;
	logic signed [35:0] mx_s1, my_s1;
	logic dx_v, dy_v, c_v;
	lbm_pkg::word_t ux, uy;
	tag_t tx_out, ty_out;
	lbm_pkg::node_out_t c_res;
	logic out_v_q;
	lbm_pkg::node_out_t out_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= lbm_pkg::RELAX_RST;
			iss_q <= lbm_pkg::ISS_RST;
		end else if (cfg.valid && cfg.index[31:1] == '0) begin
			case (cfg.index[0])
				lbm_pkg::CFG_RELAX_RATE: relax_q <= cfg.data[lbm_pkg::RELAX_W-1:0];
				lbm_pkg::CFG_INV_SOUND_SPEED_SQ: iss_q <= cfg.data[lbm_pkg::ISS_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !out_v_q || node_out.ready;
	assign node_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= node_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [35:0] s, x, y;
			s = '0; x = '0; y = '0;
			for (int k = 0; k < N; k++) begin
				s = s + 36'(node_in.payload.f[k]);
				x = x + 36'(lbm_pkg::dir_cx(k)) * 36'(node_in.payload.f[k]);
				y = y + 36'(lbm_pkg::dir_cy(k)) * 36'(node_in.payload.f[k]);
			end
			in_s1 <= node_in.payload;
			rho_s1 <= lbm_pkg::sat32(128'(s));
			mx_s1 <= x;
			my_s1 <= y;
		end
	end

	lbm_divider #(.FRAC_BITS(FRAC_BITS), .TAGW($bits(tag_t))) u_div_x (
		.clk, .arst_n, .en, .in_valid(v_s1), .num(mx_s1), .den(rho_s1),
		.tag_in({in_s1.f, in_s1.apply_collision, rho_s1, my_s1}),
		.out_valid(dx_v), .quo(ux), .tag_out(tx_out)
	);

	lbm_divider #(.FRAC_BITS(FRAC_BITS), .TAGW($bits(tag_t))) u_div_y (
		.clk, .arst_n, .en, .in_valid(v_s1), .num(my_s1), .den(rho_s1),
		.tag_in({in_s1.f, in_s1.apply_collision, rho_s1, my_s1}),
		.out_valid(dy_v), .quo(uy), .tag_out(ty_out)
	);

	lbm_collide #(.FRAC_BITS(FRAC_BITS)) u_collide (
		.clk, .arst_n, .en, .in_valid(dx_v), .f(tx_out.f), .apply(tx_out.apply),
		.rho(tx_out.rho), .ux(ux), .uy(uy), .kk(iss_q), .om(relax_q),
		.out_valid(c_v), .res(c_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= c_v;
	end
	always_ff @(posedge clk) begin
		if (en) out_q <= c_res;
	end
	assign node_out.valid = out_v_q;
	assign node_out.payload = out_q;

`ifndef SYNTHESIS
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dx_v == dy_v) else $error("divider lanes out of step");
	a_div_tag: assert property (@(posedge clk) disable iff (!arst_n)
		dx_v |-> tx_out == ty_out) else $error("divider tags differ");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !node_out.ready |=> out_v_q && $stable(out_q))
		else $error("output dropped under stall");
`endif
endmodule

// File: rtl/lbm_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for velocity: one quotient bit per stage.
module lbm_divider #(
	parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF,
	parameter int TAGW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [35:0] num,
	input logic signed [31:0] den,
	input logic [TAGW-1:0] tag_in,
	output logic out_valid,
	output logic signed [31:0] quo,
	output logic [TAGW-1:0] tag_out
);
	localparam int NB = FRAC_BITS + 36;
	localparam int RW = 33;

	logic [NB:0] v_q;
	logic [NB:0][35:0] mag_q;
	logic [NB:0][RW-1:0] rem_q;
	logic [NB:0][32:0] q_q;
	logic [NB:0] ovf_q, neg_q, pos_q;
	logic [NB:0][31:0] d_q;
	logic [NB:0][TAGW-1:0] t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NB-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q[0] <= num[35] ? 36'(-num) : 36'(num);
			neg_q[0] <= num[35];
			pos_q[0] <= (den > 0);
			d_q[0] <= den;
			rem_q[0] <= '0;
			q_q[0] <= '0;
			ovf_q[0] <= 1'b0;
			t_q[0] <= tag_in;
			for (int s = 1; s <= NB; s++) begin
				automatic int i = NB - s;
				automatic logic bitv;
				automatic logic [RW:0] r;
				automatic logic [32:0] qn;
				bitv = (i >= FRAC_BITS) ?
					mag_q[s-1][(i >= FRAC_BITS) ? (i - FRAC_BITS) : 0] : 1'b0;
				r = {rem_q[s-1], bitv};
				qn = {q_q[s-1][31:0], 1'b0};
				if (r >= {2'b0, d_q[s-1]}) begin
					r = r - {2'b0, d_q[s-1]};
					qn[0] = 1'b1;
				end
				rem_q[s] <= r[RW-1:0];
				q_q[s] <= qn;
				ovf_q[s] <= ovf_q[s-1] | q_q[s-1][32] | qn[32];
				mag_q[s] <= mag_q[s-1];
				neg_q[s] <= neg_q[s-1];
				pos_q[s] <= pos_q[s-1];
				d_q[s] <= d_q[s-1];
				t_q[s] <= t_q[s-1];
			end
		end
	end

	always_comb begin
		logic [32:0] q;
		q = q_q[NB];
		if (ovf_q[NB] || q > 33'h080000000) q = 33'h080000000;
		if (!pos_q[NB]) quo = '0;
		else if (neg_q[NB]) quo = 32'(-q);
		else quo = (q[31]) ? 32'sh7fffffff : q[31:0];
	end
	assign out_valid = v_q[NB];
	assign tag_out = t_q[NB];
endmodule

// File: rtl/lbm_collide.sv
`timescale 1ns / 1ps
// Equilibrium and relaxation pipeline: six register stages.
module lbm_collide #(
	parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input lbm_pkg::pop_t f,
	input logic apply,
	input lbm_pkg::word_t rho,
	input lbm_pkg::word_t ux,
	input lbm_pkg::word_t uy,
	input logic [lbm_pkg::ISS_W-1:0] kk,
	input logic [lbm_pkg::RELAX_W-1:0] om,
	output logic out_valid,
	output lbm_pkg::node_out_t res
);
	localparam int N = lbm_pkg::NDIR;
	localparam logic [63:0] DIV9_MUL = 64'd15270994831;
	localparam int DIV9_SH = 37;
	typedef logic signed [127:0] w_t;
	typedef logic signed [63:0] dw_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	lbm_pkg::pop_t f_s1, f_s2, f_s3, f_s4, f_s5, f_s6;
	logic ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6;
	lbm_pkg::word_t rho_s1, rho_s2, rho_s3, rho_s4, rho_s5, rho_s6;
	lbm_pkg::word_t ux_s1, ux_s2, ux_s3, ux_s4, ux_s5, ux_s6;
	lbm_pkg::word_t uy_s1, uy_s2, uy_s3, uy_s4, uy_s5, uy_s6;
	lbm_pkg::word_t c2_s1, ch_s1, c2_s2, kk_s1;
	lbm_pkg::word_t [N-1:0] e_s1, t1_s2, ee_s2, t2_s3, s_s4;
	lbm_pkg::word_t [N-1:0] rw_s1, rw_s2, rw_s3, rw_s4;
	lbm_pkg::word_t usq_s2, t3_s3;
	logic signed [63:0] uxx_s1, uyy_s1;
	dw_t [N-1:0] feq_s5;
	dw_t [N-1:0] g_s6;
	logic [lbm_pkg::RELAX_W-1:0] om_s1, om_s2, om_s3, om_s4, om_s5;
	lbm_pkg::word_t [N-1:0] t1_s3;

	function automatic w_t qm(input w_t a, input w_t b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	// floor(n/36) as floor(floor(n/4)/9); the nine is a reciprocal multiply
	function automatic lbm_pkg::word_t div36_floor(input w_t n);
		w_t m, u, q;
		m = n >>> 2;
		u = (m < 0) ? -m - 1 : m;
		q = (u * w_t'(DIV9_MUL)) >>> DIV9_SH;
		return lbm_pkg::word_t'((m < 0) ? -q - 1 : q);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {in_valid, v_s1, v_s2, v_s3, v_s4, v_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= f; ap_s1 <= apply; rho_s1 <= rho; ux_s1 <= ux; uy_s1 <= uy;
			om_s1 <= om;
			kk_s1 <= lbm_pkg::word_t'(kk);
			c2_s1 <= lbm_pkg::sat32((w_t'(kk) * w_t'(kk)) >>> (FRAC_BITS + 1));
			ch_s1 <= lbm_pkg::word_t'(kk >> 1);
			uxx_s1 <= 64'(qm(w_t'(ux), w_t'(ux)));
			uyy_s1 <= 64'(qm(w_t'(uy), w_t'(uy)));
			for (int k = 0; k < N; k++) begin
				e_s1[k] <= lbm_pkg::sat32(w_t'(lbm_pkg::dir_cx(k)) * w_t'(ux)
					+ w_t'(lbm_pkg::dir_cy(k)) * w_t'(uy));
				rw_s1[k] <= div36_floor(w_t'(rho) * w_t'(lbm_pkg::dir_wnum(k)));
			end

			f_s2 <= f_s1; ap_s2 <= ap_s1; rho_s2 <= rho_s1; ux_s2 <= ux_s1; uy_s2 <= uy_s1;
			om_s2 <= om_s1; rw_s2 <= rw_s1; c2_s2 <= c2_s1;
			usq_s2 <= lbm_pkg::sat32(w_t'(uxx_s1) + w_t'(uyy_s1));
			for (int k = 0; k < N; k++) begin
				t1_s2[k] <= lbm_pkg::sat32(qm(w_t'(kk_s1), w_t'(e_s1[k])));
				ee_s2[k] <= lbm_pkg::sat32(qm(w_t'(e_s1[k]), w_t'(e_s1[k])));
			end

			f_s3 <= f_s2; ap_s3 <= ap_s2; rho_s3 <= rho_s2; ux_s3 <= ux_s2; uy_s3 <= uy_s2;
			om_s3 <= om_s2; rw_s3 <= rw_s2; t1_s3 <= t1_s2;
			t3_s3 <= lbm_pkg::sat32(qm(w_t'(ch_s1), w_t'(usq_s2)));
			for (int k = 0; k < N; k++)
				t2_s3[k] <= lbm_pkg::sat32(qm(w_t'(c2_s2), w_t'(ee_s2[k])));

			f_s4 <= f_s3; ap_s4 <= ap_s3; rho_s4 <= rho_s3; ux_s4 <= ux_s3; uy_s4 <= uy_s3;
			om_s4 <= om_s3; rw_s4 <= rw_s3;
			for (int k = 0; k < N; k++)
				s_s4[k] <= lbm_pkg::sat32(w_t'(t1_s3[k]) + w_t'(t2_s3[k]) - w_t'(t3_s3));

			f_s5 <= f_s4; ap_s5 <= ap_s4; rho_s5 <= rho_s4; ux_s5 <= ux_s4; uy_s5 <= uy_s4;
			om_s5 <= om_s4;
			for (int k = 0; k < N; k++)
				feq_s5[k] <= 64'(w_t'(rw_s4[k]) + qm(w_t'(rw_s4[k]), w_t'(s_s4[k])));

			f_s6 <= f_s5; ap_s6 <= ap_s5; rho_s6 <= rho_s5; ux_s6 <= ux_s5; uy_s6 <= uy_s5;
			for (int k = 0; k < N; k++)
				g_s6[k] <= 64'(w_t'(f_s5[k]) - qm(w_t'(f_s5[k]) - w_t'(feq_s5[k]), w_t'(om_s5)));
		end
	end

	always_comb begin
		for (int k = 0; k < N; k++)
			res.g[k] = ap_s6 ? lbm_pkg::sat32(w_t'(g_s6[k])) : f_s6[k];
		res.density = rho_s6;
		res.velocity_x = ux_s6;
		res.velocity_y = uy_s6;
	end
	assign out_valid = v_s6;
endmodule
